// File: rtl/core/text_console_cursor_engine_assert.svh
// Assertion macros shared by the console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tcce_pkg.sv
package tcce_pkg;

   localparam int unsigned MAX_HISTORY_ROWS = 256;
   localparam int unsigned SCREEN_COLS      = 80;
   localparam int unsigned SCREEN_ROWS      = 25;
   localparam int unsigned TAB_WIDTH        = 4;
   localparam int unsigned QUEUE_DEPTH      = 2;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_LINE_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_VIEW_ROWS     = 3'd1;
   localparam logic [2:0] CSR_HISTORY_ROWS  = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_CELL  = 3'd3;
   localparam logic [2:0] CSR_SCROLL_OFFSET = 3'd4;
   localparam logic [2:0] CSR_RENDER_COL    = 3'd5;
   localparam logic [2:0] CSR_RENDER_ROW    = 3'd6;

   // register reset values
   localparam logic [6:0]  RST_LINE_WIDTH   = 7'd80;
   localparam logic [4:0]  RST_VIEW_ROWS    = 5'd25;
   localparam logic [8:0]  RST_HISTORY_ROWS = 9'd256;
   localparam logic [15:0] RST_DEFAULT_CELL = 16'h0700;

   // character codes
   localparam logic [7:0] CHAR_ESCAPE    = 8'hFF;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [7:0] CHAR_REPLACE   = 8'h08;

   typedef enum logic [1:0] {
      KIND_SPAN   = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CURSOR = 2'd2
   } kind_type;

   // clamped configuration seen by both halves
   typedef struct packed {
      logic [6:0]  width;
      logic [4:0]  vrows;
      logic [8:0]  hrows;
      logic [15:0] dcell;
      logic [7:0]  scroll_off;
      logic [6:0]  rc;
      logic [4:0]  rr;
   } cfg_type;

   // classified command handed from front to back
   typedef struct packed {
      logic        span;
      logic        scroll;
      logic [7:0]  srow;
      logic [6:0]  scol;
      logic [6:0]  scnt;
      logic [15:0] scell;
      logic [6:0]  col;
      logic [7:0]  row;
      logic [7:0]  sx;
      logic [5:0]  sy;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  srow;
      logic [6:0]  scol;
      logic [6:0]  scnt;
      logic [15:0] scell;
      logic [6:0]  col;
      logic [7:0]  row;
      logic [7:0]  sx;
      logic [5:0]  sy;
      logic        last;
   } beat_type;

endpackage

// File: rtl/core/tcce_if.sv
interface tcce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic [7:0] attribute;
   logic       apply_white_spaces;

   modport source (output valid, output char_code, output attribute,
                   output apply_white_spaces, input ready);
   modport sink (input valid, input char_code, input attribute,
                 input apply_white_spaces, output ready);
endinterface

interface tcce_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  span_row;
   logic [6:0]  span_col;
   logic [6:0]  span_count;
   logic [15:0] cell_value;
   logic [6:0]  cursor_col;
   logic [7:0]  cursor_row;
   logic [7:0]  screen_cursor_col;
   logic [5:0]  screen_cursor_row;
   logic        last;

   modport source (output valid, output kind, output span_row, output span_col,
                   output span_count, output cell_value, output cursor_col,
                   output cursor_row, output screen_cursor_col,
                   output screen_cursor_row, output last, input ready);
   modport sink (input valid, input kind, input span_row, input span_col,
                 input span_count, input cell_value, input cursor_col,
                 input cursor_row, input screen_cursor_col,
                 input screen_cursor_row, input last, output ready);
endinterface

// File: rtl/core/tcce_front.sv
module tcce_front
   import tcce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   tcce_req_if.sink req_bus,
   input  cfg_type  cfg,
   input  logic     q_full,
   output logic     push,
   output cmd_type  cmd
);

   localparam int unsigned ADV_W = $clog2(TAB_WIDTH + 1);

   logic [6:0]       cur_col_ff, col0, col_fin, room;
   logic [7:0]       cur_row_ff, row0, row_up, row_fin, rel;
   logic             esc_ff, esc_in;
   logic [7:0]       nc;
   logic [8:0]       nr;
   logic [ADV_W-1:0] adv;
   logic [7:0]       ch;
   logic [4:0]       rel_cap;

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;
   assign ch            = req_bus.char_code;

   always_comb begin
      // saturate a cursor left outside the window by a register change
      col0   = (cur_col_ff >= cfg.width) ? cfg.width - 7'd1 : cur_col_ff;
      row0   = ({1'b0, cur_row_ff} >= cfg.hrows) ? 8'(cfg.hrows - 9'd1) : cur_row_ff;
      row_up = (row0 != 8'd0) ? row0 - 8'd1 : 8'd0;
      room   = cfg.width - col0;
      adv    = ADV_W'(TAB_WIDTH - (int'(col0) % TAB_WIDTH));

      cmd    = '0;
      nc     = {1'b0, col0};
      nr     = {1'b0, row0};
      esc_in = esc_ff;

      if (esc_ff) begin
         esc_in    = 1'b0;
         cmd.span  = 1'b1;
         cmd.srow  = row0;
         cmd.scol  = col0;
         cmd.scnt  = 7'd1;
         cmd.scell = {req_bus.attribute, ch};
         nc        = {1'b0, col0} + 8'd1;
      end else if (ch == CHAR_ESCAPE) begin
         esc_in = 1'b1;
      end else begin
         case (ch)
            CHAR_LF: begin
               cmd.span  = req_bus.apply_white_spaces;
               cmd.srow  = row0;
               cmd.scol  = col0;
               cmd.scnt  = room;
               cmd.scell = cfg.dcell;
               nc        = 8'd0;
               nr        = {1'b0, row0} + 9'd1;
            end
            CHAR_CR: begin
               cmd.span  = req_bus.apply_white_spaces;
               cmd.scol  = 7'd0;
               cmd.scell = cfg.dcell;
               if (col0 == 7'd0) begin
                  // stay on the top row rather than wrap
                  nr       = {1'b0, row_up};
                  cmd.srow = row_up;
                  cmd.scnt = cfg.width;
               end else begin
                  cmd.srow = row0;
                  cmd.scnt = col0;
               end
               nc = 8'd0;
            end
            CHAR_TAB: begin
               cmd.span  = req_bus.apply_white_spaces;
               cmd.srow  = row0;
               cmd.scol  = col0;
               cmd.scnt  = (7'(adv) < room) ? 7'(adv) : room;
               cmd.scell = cfg.dcell;
               nc        = {1'b0, col0} + 8'(adv);
            end
            CHAR_BACKSPACE: begin
               if (col0 == 7'd0) begin
                  nr = {1'b0, row_up};
                  nc = {1'b0, cfg.width - 7'd1};
               end else begin
                  nc = {1'b0, col0 - 7'd1};
               end
               cmd.span  = req_bus.apply_white_spaces;
               cmd.srow  = nr[7:0];
               cmd.scol  = nc[6:0];
               cmd.scnt  = 7'd1;
               cmd.scell = cfg.dcell;
            end
            default: begin
               cmd.span  = 1'b1;
               cmd.srow  = row0;
               cmd.scol  = col0;
               cmd.scnt  = 7'd1;
               if (ch inside {[CHAR_SPACE:CHAR_TILDE]}) begin
                  cmd.scell = {req_bus.attribute, ch};
               end else begin
                  cmd.scell = {req_bus.attribute, CHAR_REPLACE};
               end
               nc = {1'b0, col0} + 8'd1;
            end
         endcase
      end

      // wrap at the line end, then scroll the history when it overflows
      if (nc >= {1'b0, cfg.width}) begin
         nc = 8'd0;
         nr = nr + 9'd1;
      end
      if (nr >= cfg.hrows) begin
         nr         = cfg.hrows - 9'd1;
         cmd.scroll = 1'b1;
      end

      col_fin = nc[6:0];
      row_fin = nr[7:0];
      rel     = (row_fin > cfg.scroll_off) ? row_fin - cfg.scroll_off : 8'd0;
      rel_cap = (rel > {3'd0, cfg.vrows - 5'd1}) ? cfg.vrows - 5'd1 : rel[4:0];

      cmd.col = col_fin;
      cmd.row = row_fin;
      cmd.sx  = {1'b0, col_fin} + {1'b0, cfg.rc};
      cmd.sy  = {1'b0, rel_cap} + {1'b0, cfg.rr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= 7'd0;
         cur_row_ff <= 8'd0;
         esc_ff     <= 1'b0;
      end else if (push) begin
         cur_col_ff <= col_fin;
         cur_row_ff <= row_fin;
         esc_ff     <= esc_in;
      end
   end

endmodule

// File: rtl/core/tcce_queue.sv
`include "text_console_cursor_engine_assert.svh"

module tcce_queue
   import tcce_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    valid,
   output cmd_type head,
   input  logic    pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type          store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TCCE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `TCCE_ASSERT_NEXT(a_count_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count lost a push")

endmodule

// File: rtl/core/tcce_back.sv
`include "text_console_cursor_engine_assert.svh"

module tcce_back
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  cmd_type    head,
   output logic       pop,
   tcce_rsp_if.source rsp_bus
);

   logic     out_valid_ff, out_valid_in;
   logic     phase_ff, phase_in;
   beat_type beat_ff, beat_in;
   logic     load_ok;

   assign load_ok = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      beat_in      = beat_ff;
      pop          = 1'b0;
      if (load_ok) begin
         out_valid_in = q_valid;
         if (q_valid) begin
            beat_in.col = head.col;
            beat_in.row = head.row;
            beat_in.sx  = head.sx;
            beat_in.sy  = head.sy;
            if (head.span && !phase_ff) begin
               // span first; hold the entry when a scroll follows
               beat_in.kind  = KIND_SPAN;
               beat_in.srow  = head.srow;
               beat_in.scol  = head.scol;
               beat_in.scnt  = head.scnt;
               beat_in.scell = head.scell;
               beat_in.last  = !head.scroll;
               pop           = !head.scroll;
               phase_in      = head.scroll;
            end else if (head.scroll) begin
               beat_in.kind  = KIND_SCROLL;
               beat_in.srow  = 8'(cfg.hrows - 9'd1);
               beat_in.scol  = 7'd0;
               beat_in.scnt  = cfg.width;
               beat_in.scell = cfg.dcell;
               beat_in.last  = 1'b1;
               pop           = 1'b1;
               phase_in      = 1'b0;
            end else begin
               beat_in.kind  = KIND_CURSOR;
               beat_in.srow  = 8'd0;
               beat_in.scol  = 7'd0;
               beat_in.scnt  = 7'd0;
               beat_in.scell = 16'd0;
               beat_in.last  = 1'b1;
               pop           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.kind              = beat_ff.kind;
   assign rsp_bus.span_row          = beat_ff.srow;
   assign rsp_bus.span_col          = beat_ff.scol;
   assign rsp_bus.span_count        = beat_ff.scnt;
   assign rsp_bus.cell_value        = beat_ff.scell;
   assign rsp_bus.cursor_col        = beat_ff.col;
   assign rsp_bus.cursor_row        = beat_ff.row;
   assign rsp_bus.screen_cursor_col = beat_ff.sx;
   assign rsp_bus.screen_cursor_row = beat_ff.sy;
   assign rsp_bus.last              = beat_ff.last;

   `TCCE_ASSERT_IMP(a_phase_entry, clock, reset, phase_ff, q_valid && head.span && head.scroll, "second beat without a span and scroll entry")
   `TCCE_ASSERT_IMP(a_scroll_last, clock, reset, out_valid_ff && beat_ff.kind == KIND_SCROLL, beat_ff.last, "scroll beat not last")
   `TCCE_ASSERT_IMP(a_nonlast_span, clock, reset, out_valid_ff && !beat_ff.last, beat_ff.kind == KIND_SPAN, "only a span may precede another beat")
   `TCCE_ASSERT_NEXT(a_scroll_follows, clock, reset, out_valid_ff && !beat_ff.last && rsp_bus.ready, out_valid_ff && beat_ff.kind == KIND_SCROLL, "scroll beat missing after span")

endmodule

// File: rtl/core/text_console_cursor_engine.sv
// Path: an accepted character is written to the command queue, then loaded into
// the output beat register; a second beat (history scroll) follows the first.
// Throughput: one character per cycle while the command queue is not full; a
// character that both writes a span and scrolls the history takes two output beats.
// Reset (synchronous, active high): cursor at column 0 row 0, escape cleared,
// command queue emptied, no result beat valid, config registers at defaults.
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tcce_req_if.sink    req_bus,
   tcce_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers, kept raw as written; clamping happens below.
   logic [6:0]  line_width_ff;
   logic [4:0]  view_rows_ff;
   logic [8:0]  history_rows_ff;
   logic [15:0] default_cell_ff;
   logic [7:0]  scroll_offset_ff;
   logic [6:0]  render_col_ff;
   logic [4:0]  render_row_ff;

   cfg_type cfg;
   logic    push, q_full, q_valid, pop;
   cmd_type push_cmd, head;

   // Take a register write; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= RST_LINE_WIDTH;
         view_rows_ff     <= RST_VIEW_ROWS;
         history_rows_ff  <= RST_HISTORY_ROWS;
         default_cell_ff  <= RST_DEFAULT_CELL;
         scroll_offset_ff <= 8'd0;
         render_col_ff    <= 7'd0;
         render_row_ff    <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH:    line_width_ff    <= csr_wdata[6:0];
            CSR_VIEW_ROWS:     view_rows_ff     <= csr_wdata[4:0];
            CSR_HISTORY_ROWS:  history_rows_ff  <= csr_wdata[8:0];
            CSR_DEFAULT_CELL:  default_cell_ff  <= csr_wdata;
            CSR_SCROLL_OFFSET: scroll_offset_ff <= csr_wdata[7:0];
            CSR_RENDER_COL:    render_col_ff    <= csr_wdata[6:0];
            CSR_RENDER_ROW:    render_row_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Clamp each geometry register: sizes to at least one and at most the screen
   // (history rows at most MAX_HISTORY_ROWS), origins to the screen edge.
   always_comb begin
      cfg.width = (line_width_ff == 7'd0) ? 7'd1 :
                  (line_width_ff > 7'(SCREEN_COLS)) ? 7'(SCREEN_COLS) : line_width_ff;
      cfg.vrows = (view_rows_ff == 5'd0) ? 5'd1 :
                  (view_rows_ff > 5'(SCREEN_ROWS)) ? 5'(SCREEN_ROWS) : view_rows_ff;
      cfg.hrows = (history_rows_ff == 9'd0) ? 9'd1 :
                  (history_rows_ff > 9'(MAX_HISTORY_ROWS)) ? 9'(MAX_HISTORY_ROWS) :
                  history_rows_ff;
      cfg.dcell      = default_cell_ff;
      cfg.scroll_off = scroll_offset_ff;
      cfg.rc = (render_col_ff > 7'(SCREEN_COLS)) ? 7'(SCREEN_COLS) : render_col_ff;
      cfg.rr = (render_row_ff > 5'(SCREEN_ROWS)) ? 5'(SCREEN_ROWS) : render_row_ff;
   end

   // Front: classify each character, advance the cursor and escape state in
   // the accepting cycle, and push one command word. It stalls only when the
   // queue is full, so it keeps taking characters while a result beat waits.
   tcce_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .q_full  (q_full),
      .push    (push),
      .cmd     (push_cmd)
   );

   // Short command queue decoupling the two halves.
   tcce_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head),
      .pop      (pop)
   );

   // Back: expand each command into one or two result beats through a
   // registered output stage; pop the command with its final beat.
   tcce_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
